>>> src/three_wire_serial_master_core_macros.svh
// assertion macros for the three-wire serial master
`ifndef THREE_WIRE_SERIAL_MASTER_CORE_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("three-wire serial master check failed");

// next-cycle implication, checked out of reset
`define TWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("three-wire serial master check failed");

`endif

>>> src/tws_pkg.sv
// shared types and constants for the three-wire serial master
`timescale 1ns / 1ps

package tws_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] REG_SETUP      = 2'd0;
  localparam logic [1:0] REG_HIGH       = 2'd1;
  localparam logic [1:0] REG_LEAD       = 2'd2;
  localparam logic [1:0] REG_TURNAROUND = 2'd3;

  localparam logic [7:0] WRITE_CMD_MASK = 8'hFE;
  localparam logic [7:0] READ_CMD_BIT   = 8'h01;

  localparam logic [7:0] SETUP_RESET      = 8'd5;
  localparam logic [7:0] HIGH_RESET       = 8'd8;
  localparam logic [7:0] LEAD_RESET       = 8'd3;
  localparam logic [7:0] TURNAROUND_RESET = 8'd5;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LEAD  = 5'b00010,
    PH_SETUP = 5'b00100,
    PH_HIGH  = 5'b01000,
    PH_TURN  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_address;
    logic [7:0] write_byte;
    logic       data_pin_in;
  } tick_item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_pin_out;
    logic       data_pin_drive;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       done_res;
  } pin_item_t;

endpackage

>>> src/three_wire_serial_master_core.sv
// three-wire serial master: one tick in, one pin-level transaction out
// throughput one transaction per cycle unless res_stall holds it; the bus sequencer
// updates in a single pass between the input register and the result register
// synchronous active-high reset returns the sequencer to idle, empties both registers
// and restores the timing registers to their defaults
`timescale 1ns / 1ps

module three_wire_serial_master_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  tws_pkg::tick_item_t tick,
  output logic                res_valid,
  input  logic                res_stall,
  output tws_pkg::pin_item_t  res
);
  import tws_pkg::*;

`include "three_wire_serial_master_core_macros.svh"

  logic [7:0] setup_ticks;
  logic [7:0] high_ticks;
  logic [7:0] enable_lead_ticks;
  logic [7:0] turnaround_ticks;

  logic       item_valid;
  tick_item_t item;

  phase_t     phase,         phase_next;
  logic [3:0] bit_count,     bit_count_next;
  logic [7:0] tick_count,    tick_count_next;
  logic [7:0] command_shift, command_shift_next;
  logic [7:0] data_shift,    data_shift_next;
  logic       is_read,       is_read_next;
  logic       clock_level,   clock_level_next;
  logic [7:0] last_read,     last_read_next;
  logic       done_next;

  logic [7:0] dur_setup;
  logic [7:0] dur_high;
  logic [4:0] bit_sum;
  logic       advance;
  logic       drive;
  logic       start_read;
  pin_item_t  res_next;

  assign advance    = item_valid && (!res_valid || !res_stall);
  assign tick_stall = item_valid && !advance;
  assign dur_setup  = (setup_ticks == 8'd0) ? 8'd1 : setup_ticks;
  assign dur_high   = (high_ticks == 8'd0) ? 8'd1 : high_ticks;
  assign bit_sum    = {1'b0, bit_count} + 5'd1;
  assign start_read = (item.cmd == CMD_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_ticks       <= SETUP_RESET;
      high_ticks        <= HIGH_RESET;
      enable_lead_ticks <= LEAD_RESET;
      turnaround_ticks  <= TURNAROUND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETUP:      setup_ticks       <= cfg_data;
        REG_HIGH:       high_ticks        <= cfg_data;
        REG_LEAD:       enable_lead_ticks <= cfg_data;
        REG_TURNAROUND: turnaround_ticks  <= cfg_data;
        default:        setup_ticks       <= setup_ticks;
      endcase
    end
  end

  // bus sequencer
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    tick_count_next    = tick_count;
    command_shift_next = command_shift;
    data_shift_next    = data_shift;
    is_read_next       = is_read;
    clock_level_next   = clock_level;
    last_read_next     = last_read;
    done_next          = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
          is_read_next       = start_read;
          command_shift_next = start_read ? (item.reg_address | READ_CMD_BIT)
                                          : (item.reg_address & WRITE_CMD_MASK);
          data_shift_next    = start_read ? 8'd0 : item.write_byte;
          bit_count_next     = 4'd0;
          clock_level_next   = 1'b0;
          tick_count_next    = 8'd1;
          if (start_read && enable_lead_ticks != 8'd0) begin
            phase_next = PH_LEAD;
          end else begin
            phase_next = PH_SETUP;
          end
        end
      end
      PH_LEAD: begin
        if (tick_count >= enable_lead_ticks) begin
          phase_next       = PH_SETUP;
          tick_count_next  = 8'd1;
          clock_level_next = 1'b0;
        end else begin
          tick_count_next = tick_count + 8'd1;
        end
      end
      PH_TURN: begin
        if (tick_count >= turnaround_ticks) begin
          phase_next       = PH_SETUP;
          tick_count_next  = 8'd1;
          clock_level_next = 1'b0;
        end else begin
          tick_count_next = tick_count + 8'd1;
        end
      end
      PH_SETUP: begin
        if (tick_count >= dur_setup) begin
          if (is_read && bit_count[3]) begin
            data_shift_next = {item.data_pin_in, data_shift[7:1]};
          end
          phase_next       = PH_HIGH;
          tick_count_next  = 8'd1;
          clock_level_next = 1'b1;
        end else begin
          tick_count_next = tick_count + 8'd1;
        end
      end
      PH_HIGH: begin
        if (tick_count >= dur_high) begin
          clock_level_next = 1'b0;
          if (!bit_count[3]) begin
            command_shift_next = {1'b0, command_shift[7:1]};
          end else if (!is_read) begin
            data_shift_next = {1'b0, data_shift[7:1]};
          end
          bit_count_next = bit_sum[3:0];
          if (bit_sum[4]) begin
            phase_next      = PH_IDLE;
            tick_count_next = 8'd0;
            done_next       = 1'b1;
            if (is_read) begin
              last_read_next = data_shift;
            end
          end else if (bit_sum == 5'd8 && is_read && turnaround_ticks != 8'd0) begin
            phase_next      = PH_TURN;
            tick_count_next = 8'd1;
          end else begin
            phase_next      = PH_SETUP;
            tick_count_next = 8'd1;
          end
        end else begin
          tick_count_next = tick_count + 8'd1;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        clock_level_next = 1'b0;
        tick_count_next  = 8'd0;
      end
    endcase
  end

  assign drive = (phase_next == PH_SETUP || phase_next == PH_HIGH)
                 && !(is_read_next && bit_count_next[3]);

  always_comb begin
    res_next.chip_enable    = (phase_next != PH_IDLE);
    res_next.serial_clock   = clock_level_next;
    res_next.data_pin_drive = drive;
    res_next.data_pin_out   = drive && (bit_count_next[3] ? data_shift_next[0]
                                                          : command_shift_next[0]);
    res_next.busy_res       = (phase_next != PH_IDLE);
    res_next.read_byte      = last_read_next;
    res_next.done_res       = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      res_valid     <= 1'b0;
      phase         <= PH_IDLE;
      bit_count     <= 4'd0;
      tick_count    <= 8'd0;
      command_shift <= 8'd0;
      data_shift    <= 8'd0;
      is_read       <= 1'b0;
      clock_level   <= 1'b0;
      last_read     <= 8'd0;
    end else begin
      if (!tick_stall) begin
        item_valid <= tick_valid;
      end
      if (advance) begin
        res_valid     <= 1'b1;
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        tick_count    <= tick_count_next;
        command_shift <= command_shift_next;
        data_shift    <= data_shift_next;
        is_read       <= is_read_next;
        clock_level   <= clock_level_next;
        last_read     <= last_read_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      item <= tick;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  `TWS_ASSERT_NOW(a_done_ends_transfer, res_valid && res.done_res,
                  !res.busy_res && !res.chip_enable && !res.serial_clock)
  `TWS_ASSERT_NOW(a_idle_bus_quiet, res_valid && !res.busy_res,
                  !res.serial_clock && !res.data_pin_drive && !res.data_pin_out)
  `TWS_ASSERT_NEXT(a_write_starts_setup,
                   advance && phase == PH_IDLE && item.cmd == CMD_WRITE,
                   phase == PH_SETUP && !is_read)
  `TWS_ASSERT_NEXT(a_read_data_released,
                   advance && is_read_next && bit_count_next[3] && phase_next != PH_IDLE,
                   !res.data_pin_drive)

endmodule
